### rtl/core/nhqp_pkg.sv
// ----------------------------------------------------------------------------
// nhqp_pkg: shared types and constants for the NVMe host queue pair
// Payload structs, result kinds, register indexes and command encodings.
// ----------------------------------------------------------------------------
package nhqp_pkg;

  localparam int unsigned PTR_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_MASK   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSFER = 8'd1;

  localparam logic [15:0] QUEUE_MASK_RST   = 16'd63;
  localparam logic [16:0] MAX_TRANSFER_RST = 17'd256;

  localparam logic [7:0]  OPC_WRITE   = 8'h01;
  localparam logic [7:0]  OPC_READ    = 8'h02;
  localparam logic [16:0] NLB_LIMIT   = 17'd65536;
  localparam logic [16:0] NLB_ONE     = 17'd1;
  localparam logic [31:0] CDW12_BASE  = 32'h8000_0000;
  localparam logic [15:0] CPL_SC_MASK = 16'h01fe;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_CPL    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    logic        cmd;
    logic        is_write;
    logic [62:0] start_block;
    logic [16:0] block_count;
    logic [63:0] buffer_address;
    logic [15:0] cpl_status;
    logic [15:0] cpl_sq_head;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] cdw0;
    logic [63:0] prp1;
    logic [31:0] cdw10;
    logic [31:0] cdw11;
    logic [31:0] cdw12;
    logic [15:0] doorbell_value;
    logic        cpl_ok;
  } out_t;

endpackage

### rtl/core/nhqp_step.sv
// ----------------------------------------------------------------------------
// nhqp_step: per-word command build and completion check
// Combinational next-state and result for one submit or completion word.
// ----------------------------------------------------------------------------
module nhqp_step #(
  parameter int unsigned PTR_BITS = nhqp_pkg::PTR_BITS_DEF
) (
  input  nhqp_pkg::in_t      item_i,
  input  logic [15:0]        queue_mask_i,
  input  logic [16:0]        max_transfer_i,
  input  logic [PTR_BITS-1:0] sq_tail_i,
  input  logic [PTR_BITS-1:0] sq_head_i,
  input  logic [PTR_BITS-1:0] cq_head_i,
  input  logic               cq_phase_i,
  output logic [PTR_BITS-1:0] sq_tail_o,
  output logic [PTR_BITS-1:0] sq_head_o,
  output logic [PTR_BITS-1:0] cq_head_o,
  output logic               cq_phase_o,
  output nhqp_pkg::out_t     res_o
);
  import nhqp_pkg::*;

  logic [PTR_BITS-1:0] mask;
  logic [PTR_BITS-1:0] tail_inc;
  logic [PTR_BITS-1:0] cq_inc;
  logic                full;
  logic                phase_ok;
  logic [16:0]         limit;
  logic [16:0]         count;
  logic [16:0]         clamped;
  logic [16:0]         nlb;
  logic [7:0]          opc;

  assign mask     = queue_mask_i[PTR_BITS-1:0];
  assign tail_inc = (sq_tail_i + PTR_BITS'(1)) & mask;
  assign cq_inc   = (cq_head_i + PTR_BITS'(1)) & mask;
  assign full     = (tail_inc == sq_head_i);
  assign phase_ok = (item_i.cpl_status[0] == cq_phase_i);

  always_comb begin
    // clamp the limit to [1, NLB_LIMIT], then the count to [1, limit]
    if (max_transfer_i == '0) begin
      limit = NLB_ONE;
    end else if (max_transfer_i > NLB_LIMIT) begin
      limit = NLB_LIMIT;
    end else begin
      limit = max_transfer_i;
    end
    count   = (item_i.block_count == '0) ? NLB_ONE : item_i.block_count;
    clamped = (count > limit) ? limit : count;
    nlb     = clamped - NLB_ONE;
    opc     = item_i.is_write ? OPC_WRITE : OPC_READ;
  end

  always_comb begin
    sq_tail_o  = sq_tail_i;
    sq_head_o  = sq_head_i;
    cq_head_o  = cq_head_i;
    cq_phase_o = cq_phase_i;
    res_o      = '0;
    res_o.kind = KIND_REJECT;
    if (!item_i.cmd) begin
      if (!full) begin
        sq_tail_o            = tail_inc;
        res_o.kind           = KIND_CMD;
        res_o.cdw0           = {16'(sq_tail_i), 8'h00, opc};
        res_o.prp1           = item_i.buffer_address;
        res_o.cdw10          = item_i.start_block[31:0];
        res_o.cdw11          = {1'b0, item_i.start_block[62:32]};
        res_o.cdw12          = CDW12_BASE | {16'h0000, nlb[15:0]};
        res_o.doorbell_value = 16'(tail_inc);
      end
    end else if (phase_ok) begin
      cq_head_o            = cq_inc;
      // flip the expected phase when the head wraps
      cq_phase_o           = (cq_inc == '0) ? ~cq_phase_i : cq_phase_i;
      sq_head_o            = item_i.cpl_sq_head[PTR_BITS-1:0];
      res_o.kind           = KIND_CPL;
      res_o.doorbell_value = 16'(cq_inc);
      res_o.cpl_ok         = ((item_i.cpl_status & CPL_SC_MASK) == '0);
    end
  end

endmodule

### rtl/core/nvme_host_queue_pair.sv
// ----------------------------------------------------------------------------
// nvme_host_queue_pair: host side of one NVMe I/O queue pair
// Builds read/write commands, tracks tail, heads and completion phase.
// ----------------------------------------------------------------------------
// Each input word yields one result word: a command, an accepted completion,
// or a reject (queue full or phase mismatch, state unchanged). A word is
// taken every cycle while in_ready_o is high, i.e. while the single result
// register is empty or being drained; the result is held there and shows on
// the output in the cycle after accept. Configuration writes take effect at
// once; the user must issue them only while the block is idle (unenforced).
module nvme_host_queue_pair #(
  parameter int unsigned PTR_BITS = nhqp_pkg::PTR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  nhqp_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output nhqp_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nhqp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nhqp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import nhqp_pkg::*;

  logic [15:0]         queue_mask_q;
  logic [16:0]         max_transfer_q;
  logic [PTR_BITS-1:0] sq_tail_q, sq_tail_d;
  logic [PTR_BITS-1:0] sq_head_q, sq_head_d;
  logic [PTR_BITS-1:0] cq_head_q, cq_head_d;
  logic                cq_phase_q, cq_phase_d;
  logic                out_valid_q;
  out_t                out_q, res;
  logic                in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  nhqp_step #(
    .PTR_BITS(PTR_BITS)
  ) u_step (
    .item_i         (in_data_i),
    .queue_mask_i   (queue_mask_q),
    .max_transfer_i (max_transfer_q),
    .sq_tail_i      (sq_tail_q),
    .sq_head_i      (sq_head_q),
    .cq_head_i      (cq_head_q),
    .cq_phase_i     (cq_phase_q),
    .sq_tail_o      (sq_tail_d),
    .sq_head_o      (sq_head_d),
    .cq_head_o      (cq_head_d),
    .cq_phase_o     (cq_phase_d),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mask_q   <= QUEUE_MASK_RST;
      max_transfer_q <= MAX_TRANSFER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_QUEUE_MASK:   queue_mask_q   <= cfg_data_i[15:0];
        CFG_MAX_TRANSFER: max_transfer_q <= cfg_data_i[16:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tail_q   <= '0;
      sq_head_q   <= '0;
      cq_head_q   <= '0;
      cq_phase_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      sq_tail_q   <= sq_tail_d;
      sq_head_q   <= sq_head_d;
      cq_head_q   <= cq_head_d;
      cq_phase_q  <= cq_phase_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  // a reject leaves every pointer and the phase untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.kind == KIND_REJECT) |=>
      ($stable(sq_tail_q) && $stable(sq_head_q) && $stable(cq_head_q) &&
       $stable(cq_phase_q)))
    else $error("reject changed queue state");

  // the expected phase only flips when the completion head wraps to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cq_phase_q) |-> (cq_head_q == '0))
    else $error("phase flipped without head wrap");

  // an emitted command carries the new tail as doorbell and no completion flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.kind == KIND_CMD) |=>
      (out_data_o.doorbell_value == 16'(sq_tail_q) && !out_data_o.cpl_ok &&
       out_data_o.cdw12[31]))
    else $error("command result inconsistent with tail");
`endif

endmodule

### tb/nvme_host_queue_pair_tb.sv
// ----------------------------------------------------------------------------
// nvme_host_queue_pair_tb: self-checking bench for the NVMe host queue pair
// Drives submit and completion words through the valid/ready channels,
// predicts every result word from a local copy of the pointers, phase and
// registers, and checks each one in order. Covers full queue, phase
// mismatch, count clamping, odd masks and random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import nhqp_pkg::*;

class qp_tracker;
  localparam logic [15:0] PTR_ONES = 16'((32'd1 << PTR_BITS_DEF) - 32'd1);

  out_t        pending_results[$];
  int unsigned mismatches;
  logic [15:0] qmask;
  logic [16:0] xfer_limit;
  logic [15:0] sq_tail;
  logic [15:0] sq_head;
  logic [15:0] cq_head;
  logic        cq_phase;

  function new();
    mismatches = 0;
    qmask      = QUEUE_MASK_RST;
    xfer_limit = MAX_TRANSFER_RST;
    sq_tail    = '0;
    sq_head    = '0;
    cq_head    = '0;
    cq_phase   = 1'b1;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_QUEUE_MASK: begin
        qmask = data[15:0];
      end
      CFG_MAX_TRANSFER: begin
        xfer_limit = data[16:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Work out the result word of one input word and advance the pointers.
  function out_t build_result(in_t w);
    out_t        r;
    logic [15:0] m;
    logic [15:0] nxt;
    logic [16:0] lim;
    logic [16:0] cnt;
    r = '0;
    m = qmask & PTR_ONES;
    if (!w.cmd) begin
      nxt = (sq_tail + 16'd1) & m;
      if (nxt == sq_head) begin
        r.kind = KIND_REJECT;
        return r;
      end
      lim = (xfer_limit == '0) ? NLB_ONE : xfer_limit;
      if (lim > NLB_LIMIT) lim = NLB_LIMIT;
      cnt = (w.block_count == '0) ? NLB_ONE : w.block_count;
      if (cnt > lim) cnt = lim;
      r.kind  = KIND_CMD;
      r.cdw0  = {sq_tail, 8'h00, (w.is_write ? OPC_WRITE : OPC_READ)};
      r.prp1  = w.buffer_address;
      r.cdw10 = w.start_block[31:0];
      r.cdw11 = {1'b0, w.start_block[62:32]};
      r.cdw12 = CDW12_BASE | 32'(cnt - NLB_ONE);
      sq_tail = nxt;
      r.doorbell_value = nxt;
    end else begin
      if (w.cpl_status[0] != cq_phase) begin
        r.kind = KIND_REJECT;
        return r;
      end
      cq_head = (cq_head + 16'd1) & m;
      // flip the phase on wrap
      if (cq_head == '0) cq_phase = ~cq_phase;
      sq_head = w.cpl_sq_head & PTR_ONES;
      r.kind           = KIND_CPL;
      r.doorbell_value = cq_head;
      r.cpl_ok         = ((w.cpl_status & CPL_SC_MASK) == '0);
    end
    return r;
  endfunction

  function void note_word(in_t w);
    pending_results.push_back(build_result(w));
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_word(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", 64'(want.kind), 64'(got.kind));
    compare_field("cdw0", 64'(want.cdw0), 64'(got.cdw0));
    compare_field("prp1", want.prp1, got.prp1);
    compare_field("cdw10", 64'(want.cdw10), 64'(got.cdw10));
    compare_field("cdw11", 64'(want.cdw11), 64'(got.cdw11));
    compare_field("cdw12", 64'(want.cdw12), 64'(got.cdw12));
    compare_field("doorbell_value", 64'(want.doorbell_value), 64'(got.doorbell_value));
    compare_field("cpl_ok", 64'(want.cpl_ok), 64'(got.cpl_ok));
  endfunction
endclass

module nvme_host_queue_pair_tb;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned ITEMS_PER_PHASE = 158;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  qp_tracker   sb = new();
  bit          idle_on     = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned stuck_cycles = 0;

  // Extremes first, then odd masks and random settings.
  int unsigned mask_plan [10] = '{63, 1, 3, 7, 0, 5, 65535, 15, 2, 255};
  int unsigned limit_plan[10] = '{256, 1, 0, 65536, 131071, 8, 3, 65535, 256, 17};

  nvme_host_queue_pair i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input in_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  // Hold off the sender until every result word is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [15:0] mask, input logic [16:0] limit);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_QUEUE_MASK;
    cfg_data_i  <= {16'($urandom), mask};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_QUEUE_MASK, cfg_data_i);
    cfg_index_i <= CFG_MAX_TRANSFER;
    cfg_data_i  <= {15'($urandom), limit};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_MAX_TRANSFER, cfg_data_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t mk_sub(bit wr, logic [62:0] lba, logic [16:0] cnt,
                                 logic [63:0] buf_addr);
    in_t w;
    w                = '0;
    w.cmd            = 1'b0;
    w.is_write       = wr;
    w.start_block    = lba;
    w.block_count    = cnt;
    w.buffer_address = buf_addr;
    return w;
  endfunction

  function automatic in_t mk_cpl(logic [15:0] head, logic [7:0] code, bit good_phase);
    in_t w;
    w             = '0;
    w.cmd         = 1'b1;
    w.cpl_status  = {7'd0, code, (good_phase ? sb.cq_phase : ~sb.cq_phase)};
    w.cpl_sq_head = head;
    return w;
  endfunction

  // Mostly device-like completions: right phase, head within the outstanding
  // range. The rest is noise.
  function automatic in_t random_word(bit tidy, int unsigned cpl_pct);
    in_t         w;
    logic [15:0] m;
    logic [15:0] inflight;
    m        = sb.qmask;
    inflight = (sb.sq_tail - sb.sq_head) & m;
    w.cmd            = ($urandom_range(0, 99) < cpl_pct);
    w.is_write       = 1'($urandom_range(0, 1));
    w.start_block    = 63'({$urandom, $urandom});
    w.buffer_address = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       w.block_count = '0;
      1:       w.block_count = NLB_LIMIT;
      2:       w.block_count = '1;
      3, 4:    w.block_count = 17'($urandom);
      5:       w.block_count = 17'(sb.xfer_limit + 17'($urandom_range(0, 2)) - 17'd1);
      default: w.block_count = 17'($urandom_range(1, 16));
    endcase
    w.cpl_status = 16'($urandom);
    if ($urandom_range(0, 1) == 1) w.cpl_status = w.cpl_status & ~CPL_SC_MASK;
    w.cpl_sq_head = 16'($urandom);
    if (tidy) begin
      w.cpl_status[0] = sb.cq_phase ^ ($urandom_range(0, 9) == 0);
      w.cpl_sq_head   = (sb.sq_head + 16'($urandom_range(0, inflight))) & m;
    end
    return w;
  endfunction

  initial begin
    int unsigned cpl_pct;
    logic [15:0] mask;
    logic [16:0] limit;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: mask 63, limit 256.
    send_word(mk_sub(1'b0, '0, '0, '0));
    send_word(mk_sub(1'b1, '1, NLB_LIMIT, '1));
    send_word(mk_sub(1'b1, 63'h2aaa_aaaa_5555_5555, '1, 64'h5555_aaaa_5555_aaaa));
    send_word(mk_sub(1'b0, 63'h1555_5555_aaaa_aaaa, 17'd256, 64'haaaa_5555_aaaa_5555));
    send_word(mk_sub(1'b0, 63'd1, 17'd257, 64'd1));
    send_word(mk_cpl(16'd2, 8'h00, 1'b1));
    send_word(mk_cpl(16'hffff, 8'hff, 1'b1));
    send_word(mk_cpl(16'd0, 8'h00, 1'b0));
    send_word(mk_cpl(16'd3, 8'h01, 1'b1));

    // Two-entry queue, limit zero: fill, reject, free one slot.
    drain();
    load_regs(16'd1, 17'd0);
    send_word(mk_cpl(16'd0, 8'h00, 1'b1));
    send_word(mk_sub(1'b1, 63'd100, 17'd5, 64'h1000));
    send_word(mk_sub(1'b0, 63'd101, 17'd5, 64'h2000));
    send_word(mk_cpl(16'd1, 8'h80, 1'b1));
    send_word(mk_sub(1'b0, 63'd102, 17'd1, 64'h3000));

    // Mask zero: every submit rejected once the head is zero, phase flips
    // on every completion.
    drain();
    load_regs(16'd0, 17'h1ffff);
    send_word(mk_cpl(16'd0, 8'h00, 1'b1));
    send_word(mk_cpl(16'd0, 8'h00, 1'b1));
    send_word(mk_sub(1'b1, 63'd7, 17'd9, 64'h4000));
    send_word(mk_cpl(16'd0, 8'h00, 1'b0));

    // Limit above the field range clamps to the largest count.
    drain();
    load_regs(16'd63, 17'h1ffff);
    send_word(mk_sub(1'b1, '1, '1, '1));
    send_word(mk_sub(1'b0, 63'd5, 17'd70000, 64'h5000));
    send_word(mk_sub(1'b1, 63'd6, 17'd65535, 64'h6000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < 10) begin
        mask  = 16'(mask_plan[p]);
        limit = 17'(limit_plan[p]);
      end else begin
        mask  = 16'($urandom_range(1, 65535));
        limit = 17'($urandom_range(0, 131071));
      end
      load_regs(mask, limit);
      idle_on = (p % 4 != 3) && (p != NUM_PHASES - 1);
      cpl_pct = $urandom_range(15, 60);
      repeat (ITEMS_PER_PHASE) begin
        send_word(random_word($urandom_range(0, 9) < 8, cpl_pct));
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
